/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define AST_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define AST_IMPLY(name, clk, rst_n, pre, post)
`define AST_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

/* sv/ahe_pkg.sv */
package ahe_pkg;

    localparam int BYTE_W = 8;
    localparam int NB_W   = 4;
    localparam int SYM_W  = 9;

    localparam logic [SYM_W-1:0] MARK_INTERNAL = 9'h100;
    localparam logic [SYM_W-1:0] MARK_NYT      = 9'h1FF;
    localparam logic [2:0]       LAST_BIT      = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHK,
        ST_LEAF,
        ST_PSTART,
        ST_PPAR,
        ST_PDATA,
        ST_EPOP,
        ST_EBIT,
        ST_RAW,
        ST_SPLIT0,
        ST_SPLIT1,
        ST_SPLIT2,
        ST_UISS,
        ST_UREC,
        ST_SCAN,
        ST_DECIDE,
        ST_ANC,
        ST_ANCD,
        ST_SWA,
        ST_SWB,
        ST_RLAL,
        ST_RLAR,
        ST_RLBL,
        ST_RLBR,
        ST_INC,
        ST_NEXT,
        ST_FIN,
        ST_FIN2
    } t_state;

endpackage

/* sv/adaptive_huffman_encoder.sv */
// Adaptive Huffman (FGK) byte encoder. Each request carries one symbol byte in tdata, with a
// tree reset flag in tuser[0] and a flush flag in tuser[1]; results are packed code bytes,
// first code bit in bit 7, with the count of valid bits in tdata[11:8] and tlast on the final
// result of each request. A request with no complete byte and no flush gives no result. The
// tree lives in a node table memory with one registered read port, so the data of each read
// is used from the port's output register. A request goes through these steps: start (with an extra
// step for a symbol already seen), trace the code path one tree level per cycle, emit the
// path bits, for a new symbol emit the raw bits, one per cycle while the output does not stall,
// and split the NYT node, then for each level of the update scan the block of equal weight
// above the node, one node per cycle, raise its weight and swap it with the leader if needed
// (with a saturated weight a swap first walks the parent chain, one level per cycle, to rule
// out an ancestor), and finish. After reset or a tree reset the root entry is written before
// the symbol is handled. A stalled output holds the encoder at its next result.
`include "assert_macros.svh"

module adaptive_huffman_encoder
    import ahe_pkg::*;
#(
    parameter int ALPHABET    = 256,
    parameter int NODE_COUNT  = 513,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  i_s_axis_tuser,   // [0] start_req, [1] final_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte, [11:8] valid_bits, [15:12] zero
    output logic        o_m_axis_tlast    // end_of_run
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int AW = $clog2(ALPHABET);
    localparam logic [IW-1:0] ROOT = IW'(NODE_COUNT - 1);
    localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w;
        logic [SYM_W-1:0]       sym;
        logic [IW-1:0]          lc;
        logic [IW-1:0]          rc;
    } t_body;

    // node table: body fields and parent links, plus symbol map and path stack
    t_body         mem_body [NODE_COUNT];
    logic [IW-1:0] mem_par  [NODE_COUNT];
    logic [IW-1:0] mem_leaf [ALPHABET];
    logic          mem_stk  [NODE_COUNT];

    t_body         rd_body;
    logic [IW-1:0] rd_par;
    logic [IW-1:0] rd_leaf;
    logic          rd_stk;

    logic          we_body, we_par, we_leaf, we_stk;
    logic [IW-1:0] wa_body, wa_par, wa_leaf_v, wa_stk, ra_node, ra_stk;
    logic [AW-1:0] wa_leaf, ra_leaf;
    t_body         wd_body;
    logic [IW-1:0] wd_par;
    logic          wd_stk;

    t_state r_state, n_state;
    logic [BYTE_W-1:0] r_sym, n_sym;
    logic r_fin, n_fin;
    logic r_need_init, n_need_init;
    logic [ALPHABET-1:0] r_leaf_v, n_leaf_v;
    logic [IW-1:0] r_nyt, n_nyt;
    logic [BYTE_W-1:0] r_acc, n_acc;
    logic [2:0] r_bcnt, n_bcnt;
    logic r_pend_v, n_pend_v;
    logic [BYTE_W-1:0] r_pend_byte, n_pend_byte;
    logic [NB_W-1:0] r_pend_nb, n_pend_nb;
    logic r_out_v, n_out_v;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [NB_W-1:0] r_out_nb, n_out_nb;
    logic r_out_last, n_out_last;
    logic r_known, n_known;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_p, n_p;
    logic [CW-1:0] r_depth, n_depth;
    logic [2:0] r_bitn, n_bitn;
    logic [IW-1:0] r_n, n_n;
    t_body r_nb, n_nb;
    logic [IW-1:0] r_np, n_np;
    logic [IW-1:0] r_lead, n_lead;
    t_body r_lb, n_lb;
    logic [IW-1:0] r_lp, n_lp;
    logic [CW-1:0] r_i, n_i;
    logic r_sv, n_sv;
    logic [IW-1:0] r_ri, n_ri;

    logic s_acc, out_free, bit_stall, do_bit, bit_val, scan_issue, scan_eq;
    logic [WEIGHT_BITS-1:0] w_inc;
    logic [AW-1:0] sym_idx;
    logic sym_in;

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_v || i_m_axis_tready;
    // a completing byte needs the pending slot emptied into the output register
    assign bit_stall = (r_bcnt == LAST_BIT) && r_pend_v && !out_free;
    assign w_inc     = (r_nb.w == WMAX) ? r_nb.w : r_nb.w + 1'b1;
    assign sym_idx   = r_sym[AW-1:0];
    assign sym_in    = {1'b0, r_sym} < SYM_W'(ALPHABET);
    assign scan_issue = r_i < CW'(NODE_COUNT);
    assign scan_eq    = rd_body.w == r_nb.w;
    assign ra_leaf    = sym_idx;
    assign ra_stk     = (r_state == ST_EPOP) ? IW'(r_depth - 1'b1) : r_depth[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_body) begin
            mem_body[wa_body] <= wd_body;
        end
        if (we_par) begin
            mem_par[wa_par] <= wd_par;
        end
        rd_body <= mem_body[ra_node];
        rd_par  <= mem_par[ra_node];
    end

    always_ff @(posedge i_clk) begin
        if (we_leaf) begin
            mem_leaf[wa_leaf] <= wa_leaf_v;
        end
        rd_leaf <= mem_leaf[ra_leaf];
    end

    always_ff @(posedge i_clk) begin
        if (we_stk) begin
            mem_stk[wa_stk] <= wd_stk;
        end
        rd_stk <= mem_stk[ra_stk];
    end

    always_comb begin
        n_state = r_state;
        n_sym = r_sym;
        n_fin = r_fin;
        n_need_init = r_need_init;
        n_leaf_v = r_leaf_v;
        n_nyt = r_nyt;
        n_acc = r_acc;
        n_bcnt = r_bcnt;
        n_pend_v = r_pend_v;
        n_pend_byte = r_pend_byte;
        n_pend_nb = r_pend_nb;
        n_out_v = r_out_v && !i_m_axis_tready;
        n_out_byte = r_out_byte;
        n_out_nb = r_out_nb;
        n_out_last = r_out_last;
        n_known = r_known;
        n_cur = r_cur;
        n_p = r_p;
        n_depth = r_depth;
        n_bitn = r_bitn;
        n_n = r_n;
        n_nb = r_nb;
        n_np = r_np;
        n_lead = r_lead;
        n_lb = r_lb;
        n_lp = r_lp;
        n_i = r_i;
        n_sv = r_sv;
        n_ri = r_ri;
        we_body = 1'b0;
        wa_body = r_n;
        wd_body = r_lb;
        we_par = 1'b0;
        wa_par = r_n;
        wd_par = r_n;
        we_leaf = 1'b0;
        wa_leaf = sym_idx;
        wa_leaf_v = r_n;
        we_stk = 1'b0;
        wa_stk = r_depth[IW-1:0];
        wd_stk = 1'b0;
        ra_node = r_n;
        do_bit = 1'b0;
        bit_val = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_sym = i_s_axis_tdata;
                    n_fin = i_s_axis_tuser[1];
                    n_depth = '0;
                    if (i_s_axis_tuser[0]) begin
                        n_leaf_v = '0;
                        n_nyt = ROOT;
                        n_acc = '0;
                        n_bcnt = '0;
                    end
                    n_state = (i_s_axis_tuser[0] || r_need_init) ? ST_INIT : ST_CHK;
                end
            end
            ST_INIT: begin
                we_body = 1'b1;
                wa_body = ROOT;
                wd_body = '{w: '0, sym: MARK_NYT, lc: '0, rc: '0};
                n_need_init = 1'b0;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (!sym_in) begin
                    n_state = ST_FIN;
                end else if (r_leaf_v[sym_idx]) begin
                    n_state = ST_LEAF;
                end else begin
                    n_cur = r_nyt;
                    n_known = 1'b0;
                    n_state = ST_PSTART;
                end
            end
            ST_LEAF: begin
                n_cur = rd_leaf;
                n_known = 1'b1;
                n_state = ST_PSTART;
            end
            ST_PSTART: begin
                ra_node = r_cur;
                n_n = r_cur;
                n_state = (r_cur == ROOT) ? ST_EPOP : ST_PPAR;
            end
            ST_PPAR: begin
                ra_node = rd_par;
                n_p = rd_par;
                n_state = ST_PDATA;
            end
            ST_PDATA: begin
                // rd holds the parent record; the grandparent read goes out at once
                we_stk = 1'b1;
                wd_stk = (rd_body.rc == r_cur);
                n_depth = r_depth + 1'b1;
                n_cur = r_p;
                ra_node = rd_par;
                n_p = rd_par;
                if (r_p == ROOT) begin
                    n_state = ST_EPOP;
                end
            end
            ST_EPOP: begin
                if (r_depth == '0) begin
                    if (r_known) begin
                        n_state = ST_UISS;
                    end else begin
                        n_bitn = LAST_BIT;
                        n_state = ST_RAW;
                    end
                end else begin
                    n_depth = r_depth - 1'b1;
                    n_state = ST_EBIT;
                end
            end
            ST_EBIT: begin
                if (!bit_stall) begin
                    do_bit = 1'b1;
                    bit_val = rd_stk;
                    n_state = ST_EPOP;
                end
            end
            ST_RAW: begin
                if (!bit_stall) begin
                    do_bit = 1'b1;
                    bit_val = r_sym[r_bitn];
                    n_bitn = r_bitn - 1'b1;
                    if (r_bitn == '0) begin
                        n_state = (r_nyt < IW'(2)) ? ST_FIN : ST_SPLIT0;
                    end
                end
            end
            ST_SPLIT0: begin
                we_body = 1'b1;
                wa_body = r_nyt;
                wd_body = '{w: '0, sym: MARK_INTERNAL, lc: r_nyt - IW'(2),
                            rc: r_nyt - IW'(1)};
                n_state = ST_SPLIT1;
            end
            ST_SPLIT1: begin
                we_body = 1'b1;
                wa_body = r_nyt - IW'(2);
                wd_body = '{w: '0, sym: MARK_NYT, lc: '0, rc: '0};
                we_par = 1'b1;
                wa_par = r_nyt - IW'(2);
                wd_par = r_nyt;
                n_state = ST_SPLIT2;
            end
            ST_SPLIT2: begin
                we_body = 1'b1;
                wa_body = r_nyt - IW'(1);
                wd_body = '{w: '0, sym: {1'b0, r_sym}, lc: '0, rc: '0};
                we_par = 1'b1;
                wa_par = r_nyt - IW'(1);
                wd_par = r_nyt;
                we_leaf = 1'b1;
                wa_leaf_v = r_nyt - IW'(1);
                n_leaf_v[sym_idx] = 1'b1;
                n_nyt = r_nyt - IW'(2);
                n_n = r_nyt - IW'(1);
                n_state = ST_UISS;
            end
            ST_UISS: begin
                ra_node = r_n;
                n_state = ST_UREC;
            end
            ST_UREC: begin
                n_nb = rd_body;
                n_np = rd_par;
                n_lead = r_n;
                n_lb = rd_body;
                n_lp = rd_par;
                n_i = CW'(r_n) + CW'(1);
                n_sv = 1'b0;
                n_state = (r_n == ROOT) ? ST_DECIDE : ST_SCAN;
            end
            ST_SCAN: begin
                // leader search walks up through the block of equal weight
                ra_node = r_i[IW-1:0];
                n_sv = scan_issue;
                if (scan_issue) begin
                    n_i = r_i + 1'b1;
                    n_ri = r_i[IW-1:0];
                end
                if (r_sv && scan_eq) begin
                    n_lead = r_ri;
                    n_lb = rd_body;
                    n_lp = rd_par;
                end
                if ((r_sv && !scan_eq) || !scan_issue) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_lead == r_n || r_lead == r_np) begin
                    n_lead = r_n;
                    n_lb = r_nb;
                    n_lp = r_np;
                    n_state = ST_INC;
                end else if (r_nb.w == WMAX && r_np != ROOT) begin
                    // only a saturated weight lets the leader sit higher on this branch
                    n_state = ST_ANC;
                end else begin
                    n_state = ST_SWA;
                end
            end
            ST_ANC: begin
                ra_node = r_np;
                n_state = ST_ANCD;
            end
            ST_ANCD: begin
                // parent numbers rise along the branch, so passing the leader ends the walk
                if (rd_par == r_lead) begin
                    n_lead = r_n;
                    n_lb = r_nb;
                    n_lp = r_np;
                    n_state = ST_INC;
                end else if (rd_par == ROOT || rd_par > r_lead) begin
                    n_state = ST_SWA;
                end else begin
                    ra_node = rd_par;
                end
            end
            ST_SWA: begin
                we_body = 1'b1;
                wa_body = r_n;
                wd_body = r_lb;
                n_state = ST_SWB;
            end
            ST_SWB: begin
                we_body = 1'b1;
                wa_body = r_lead;
                wd_body = '{w: w_inc, sym: r_nb.sym, lc: r_nb.lc, rc: r_nb.rc};
                n_state = ST_RLAL;
            end
            ST_RLAL: begin
                if (r_lb.sym == MARK_INTERNAL) begin
                    we_par = 1'b1;
                    wa_par = r_lb.lc;
                    wd_par = r_n;
                end else if (r_lb.sym == MARK_NYT) begin
                    n_nyt = r_n;
                end else begin
                    we_leaf = 1'b1;
                    wa_leaf = r_lb.sym[AW-1:0];
                    wa_leaf_v = r_n;
                end
                n_state = ST_RLAR;
            end
            ST_RLAR: begin
                we_par = (r_lb.sym == MARK_INTERNAL);
                wa_par = r_lb.rc;
                wd_par = r_n;
                n_state = ST_RLBL;
            end
            ST_RLBL: begin
                if (r_nb.sym == MARK_INTERNAL) begin
                    we_par = 1'b1;
                    wa_par = r_nb.lc;
                    wd_par = r_lead;
                end else if (r_nb.sym == MARK_NYT) begin
                    n_nyt = r_lead;
                end else begin
                    we_leaf = 1'b1;
                    wa_leaf = r_nb.sym[AW-1:0];
                    wa_leaf_v = r_lead;
                end
                n_state = ST_RLBR;
            end
            ST_RLBR: begin
                we_par = (r_nb.sym == MARK_INTERNAL);
                wa_par = r_nb.rc;
                wd_par = r_lead;
                n_state = ST_NEXT;
            end
            ST_INC: begin
                we_body = 1'b1;
                wa_body = r_n;
                wd_body = '{w: w_inc, sym: r_nb.sym, lc: r_nb.lc, rc: r_nb.rc};
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (r_lead == ROOT) begin
                    n_state = ST_FIN;
                end else begin
                    n_n = r_lp;
                    n_state = ST_UISS;
                end
            end
            ST_FIN: begin
                if (r_fin && r_bcnt != '0) begin
                    if (!(r_pend_v && !out_free)) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out_byte = r_pend_byte;
                            n_out_nb = r_pend_nb;
                            n_out_last = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend_byte = r_acc << (NB_W'(BYTE_W) - {1'b0, r_bcnt});
                        n_pend_nb = {1'b0, r_bcnt};
                        n_acc = '0;
                        n_bcnt = '0;
                        n_state = ST_FIN2;
                    end
                end else begin
                    n_state = ST_FIN2;
                end
            end
            ST_FIN2: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v = 1'b1;
                    n_out_byte = r_pend_byte;
                    n_out_nb = r_pend_nb;
                    n_out_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // bit packer; a full byte waits in the pending slot until its successor shows or the request ends
        if (do_bit) begin
            if (r_bcnt == LAST_BIT) begin
                if (r_pend_v) begin
                    n_out_v = 1'b1;
                    n_out_byte = r_pend_byte;
                    n_out_nb = r_pend_nb;
                    n_out_last = 1'b0;
                end
                n_pend_v = 1'b1;
                n_pend_byte = {r_acc[BYTE_W-2:0], bit_val};
                n_pend_nb = NB_W'(BYTE_W);
                n_acc = '0;
                n_bcnt = '0;
            end else begin
                n_acc = {r_acc[BYTE_W-2:0], bit_val};
                n_bcnt = r_bcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_need_init <= 1'b1;
            r_leaf_v <= '0;
            r_nyt <= ROOT;
            r_acc <= '0;
            r_bcnt <= '0;
            r_pend_v <= 1'b0;
            r_out_v <= 1'b0;
            r_depth <= '0;
            r_sv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_need_init <= n_need_init;
            r_leaf_v <= n_leaf_v;
            r_nyt <= n_nyt;
            r_acc <= n_acc;
            r_bcnt <= n_bcnt;
            r_pend_v <= n_pend_v;
            r_out_v <= n_out_v;
            r_depth <= n_depth;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_fin <= n_fin;
        r_pend_byte <= n_pend_byte;
        r_pend_nb <= n_pend_nb;
        r_out_byte <= n_out_byte;
        r_out_nb <= n_out_nb;
        r_out_last <= n_out_last;
        r_known <= n_known;
        r_cur <= n_cur;
        r_p <= n_p;
        r_bitn <= n_bitn;
        r_n <= n_n;
        r_nb <= n_nb;
        r_np <= n_np;
        r_lead <= n_lead;
        r_lb <= n_lb;
        r_lp <= n_lp;
        r_i <= n_i;
        r_ri <= n_ri;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {4'b0000, r_out_nb, r_out_byte};
    assign o_m_axis_tlast  = r_out_last;

    `AST_IMPLY(a_idle_clean, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_v && r_depth == '0)
    `AST_NEXT(a_start_clears, i_clk, i_rst_n, s_acc && i_s_axis_tuser[0], r_bcnt == '0 && r_nyt == ROOT)
    `AST_IMPLY(a_pend_bits, i_clk, i_rst_n, r_pend_v, r_pend_nb != '0 && r_pend_nb <= 4'd8)

endmodule

/* tb/adaptive_huffman_encoder_test.sv */
`timescale 1ns / 1ps

module adaptive_huffman_encoder_test
    import ahe_pkg::*;
();

    localparam int NODES = 513;
    localparam int SYMS = 256;
    localparam logic [9:0] LEAF_NONE = 10'h3FF;
    localparam logic [31:0] WEIGHT_TOP = 32'hFFFF_FFFF;
    localparam int MAX_CODES = 34;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 10000;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} t_phase;

    typedef struct {
        logic [7:0] sym;
        logic       restart;
        logic       flush;
        t_phase     ph;
        bit         drain;
    } t_request;

    typedef struct {
        logic [7:0] code;
        logic [3:0] nbits;
        logic       last;
    } t_code_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    adaptive_huffman_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_request   pending[$];
    t_code_byte expected_codes[$];
    t_code_byte item_codes[$];
    t_request   cur;
    bit         in_flight = 0;
    bit         hold_on = 0;
    int         accepted = 0;
    int         errors = 0;

    // code tree model
    logic [31:0] t_weight[NODES];
    logic [9:0]  t_parent[NODES];
    logic [9:0]  t_left[NODES];
    logic [9:0]  t_right[NODES];
    logic [8:0]  t_sym[NODES];
    logic [9:0]  leaf_of[SYMS];
    int          nyt_node;
    int          root_node;
    logic [7:0]  pack_acc;
    int          pack_cnt;

    function automatic void tree_clear();
        for (int i = 0; i < NODES; i++) begin
            t_weight[i] = '0;
            t_parent[i] = '0;
            t_left[i] = '0;
            t_right[i] = '0;
            t_sym[i] = '0;
        end
        for (int i = 0; i < SYMS; i++) leaf_of[i] = LEAF_NONE;
        root_node = NODES - 1;
        nyt_node = root_node;
        t_sym[root_node] = MARK_NYT;
        pack_acc = '0;
        pack_cnt = 0;
    endfunction

    function automatic void push_code(logic [7:0] code, int nbits);
        if (item_codes.size() < MAX_CODES)
            item_codes.insert(item_codes.size(), t_code_byte'{code, 4'(nbits), 1'b0});
    endfunction

    function automatic void shift_bit(bit b);
        pack_acc = {pack_acc[6:0], b};
        pack_cnt++;
        if (pack_cnt == 8) begin
            push_code(pack_acc, 8);
            pack_acc = '0;
            pack_cnt = 0;
        end
    endfunction

    function automatic void code_path(int n);
        bit bits[$];
        int p;
        while (n != root_node && bits.size() < NODES) begin
            p = t_parent[n];
            bits.insert(bits.size(), t_right[p] == n);
            n = p;
        end
        while (bits.size() > 0) shift_bit(bits.pop_back());
    endfunction

    function automatic void relink(int slot);
        if (t_sym[slot] == MARK_INTERNAL) begin
            t_parent[t_left[slot]] = 10'(slot);
            t_parent[t_right[slot]] = 10'(slot);
        end else if (t_sym[slot] == MARK_NYT) begin
            nyt_node = slot;
        end else if (t_sym[slot] < SYMS) begin
            leaf_of[t_sym[slot]] = 10'(slot);
        end
    endfunction

    function automatic void swap_nodes(int a, int b);
        logic [31:0] w;
        logic [9:0]  l, r;
        logic [8:0]  s;
        w = t_weight[a]; t_weight[a] = t_weight[b]; t_weight[b] = w;
        s = t_sym[a]; t_sym[a] = t_sym[b]; t_sym[b] = s;
        l = t_left[a]; t_left[a] = t_left[b]; t_left[b] = l;
        r = t_right[a]; t_right[a] = t_right[b]; t_right[b] = r;
        relink(a);
        relink(b);
    endfunction

    function automatic int block_leader(int n);
        for (int i = root_node; i > n; i--)
            if (t_weight[i] == t_weight[n]) return i;
        return n;
    endfunction

    function automatic bit above(int anc, int n);
        for (int k = 0; k < NODES && n != root_node; k++) begin
            n = t_parent[n];
            if (n == anc) return 1;
        end
        return 0;
    endfunction

    function automatic void raise_weights(int n);
        int lead;
        for (int k = 0; k < NODES; k++) begin
            lead = block_leader(n);
            if (lead != n && !above(lead, n)) begin
                swap_nodes(n, lead);
                n = lead;
            end
            if (t_weight[n] != WEIGHT_TOP) t_weight[n]++;
            if (n == root_node) break;
            n = t_parent[n];
        end
    endfunction

    function automatic void encode_symbol(logic [7:0] sym);
        int old_nyt;
        if (leaf_of[sym] != LEAF_NONE) begin
            code_path(leaf_of[sym]);
            raise_weights(leaf_of[sym]);
            return;
        end
        code_path(nyt_node);
        for (int b = 7; b >= 0; b--) shift_bit(sym[b]);
        if (nyt_node < 2) return;
        old_nyt = nyt_node;
        t_sym[old_nyt] = MARK_INTERNAL;
        t_weight[old_nyt] = '0;
        t_left[old_nyt] = 10'(old_nyt - 2);
        t_right[old_nyt] = 10'(old_nyt - 1);
        for (int k = 1; k <= 2; k++) begin
            t_weight[old_nyt - k] = '0;
            t_parent[old_nyt - k] = 10'(old_nyt);
            t_left[old_nyt - k] = '0;
            t_right[old_nyt - k] = '0;
        end
        t_sym[old_nyt - 2] = MARK_NYT;
        t_sym[old_nyt - 1] = {1'b0, sym};
        nyt_node = old_nyt - 2;
        leaf_of[sym] = 10'(old_nyt - 1);
        raise_weights(old_nyt - 1);
    endfunction

    function automatic void predict_codes(t_request req);
        item_codes.delete();
        if (req.restart) tree_clear();
        encode_symbol(req.sym);
        if (req.flush && pack_cnt > 0) begin
            push_code(pack_acc << (8 - pack_cnt), pack_cnt);
            pack_acc = '0;
            pack_cnt = 0;
        end
        if (item_codes.size() > 0) item_codes[item_codes.size() - 1].last = 1'b1;
        foreach (item_codes[i]) expected_codes.insert(expected_codes.size(), item_codes[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int send_idle_pct(t_phase ph);
        return (ph == PH_SEND_IDLE) ? 81 : (ph == PH_BOTH) ? 15 : 0;
    endfunction

    function automatic int recv_stall_pct(t_phase ph);
        return (ph == PH_RECV_STALL) ? 81 : (ph == PH_BOTH) ? 15 : 0;
    endfunction

    function automatic void add_request(logic [7:0] sym, bit restart, bit flush,
                                        t_phase ph, bit drain);
        pending.insert(pending.size(), t_request'{sym, restart, flush, ph, drain});
    endfunction

    // accept requests and check results
    always @(posedge i_clk) begin
        t_code_byte want;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                predict_codes(cur);
                in_flight = 0;
                accepted++;
            end
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected result", o_m_axis_tdata, 0);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.code)
                        report_mismatch("out_byte", o_m_axis_tdata[7:0], want.code);
                    if (o_m_axis_tdata[11:8] !== want.nbits)
                        report_mismatch("valid_bits", o_m_axis_tdata[11:8], want.nbits);
                    if (o_m_axis_tdata[15:12] !== 4'h0)
                        report_mismatch("pad bits", o_m_axis_tdata[15:12], 0);
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("end_of_run", o_m_axis_tlast, want.last);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && !in_flight && pending.size() > 0
                && !(pending[0].drain && expected_codes.size() > 0)
                && $urandom_range(99) >= send_idle_pct(pending[0].ph)) begin
            cur = pending.pop_front();
            in_flight = 1;
            s_data <= cur.sym;
            s_user <= {cur.flush, cur.restart};
        end
        s_valid <= in_flight;
    end

    always @(negedge i_clk) begin
        m_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct(cur.ph));
    end

    // long receiver hold-off so the encoder backs up onto its input
    initial begin
        wait (accepted >= 40);
        hold_on = 1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on = 0;
    end

    initial begin
        int n, run_len, alpha_n, ph_idx;
        logic [7:0] alpha[$];
        t_phase ph;
        tree_clear();
        cur = '{8'h00, 1'b0, 1'b0, PH_FREE, 1'b0};

        add_request(8'h00, 1, 0, PH_FREE, 0);
        add_request(8'h00, 0, 0, PH_FREE, 0);
        add_request(8'hFF, 0, 0, PH_FREE, 0);
        add_request(8'hFF, 0, 0, PH_FREE, 0);
        add_request(8'h80, 0, 1, PH_FREE, 0);
        add_request(8'h00, 0, 1, PH_FREE, 0);
        add_request(8'h01, 0, 0, PH_FREE, 0);
        add_request(8'hAA, 1, 0, PH_FREE, 0);
        add_request(8'h55, 0, 0, PH_FREE, 0);
        // restart throws away the partial byte
        add_request(8'h0F, 1, 1, PH_FREE, 0);
        add_request(8'h0F, 0, 1, PH_FREE, 0);
        add_request(8'h0F, 0, 1, PH_FREE, 0);
        add_request(8'hF0, 0, 0, PH_FREE, 0);
        add_request(8'h0F, 0, 0, PH_FREE, 0);
        add_request(8'hF0, 0, 0, PH_FREE, 0);
        add_request(8'h0F, 0, 1, PH_FREE, 0);
        add_request(8'h7F, 0, 1, PH_FREE, 0);

        n = 0;
        ph_idx = -1;
        while (n < RANDOM_ITEMS) begin
            alpha.delete();
            if ($urandom_range(9) == 0) begin
                run_len = $urandom_range(40, 70);
                alpha_n = 256;
                for (int i = 0; i < 256; i++) alpha.insert(alpha.size(), 8'(i));
            end else begin
                run_len = $urandom_range(3, 30);
                alpha_n = $urandom_range(1, 12);
                for (int i = 0; i < alpha_n; i++) alpha.insert(alpha.size(), 8'($urandom));
            end
            for (int i = 0; i < run_len && n < RANDOM_ITEMS; i++) begin
                ph = t_phase'(n * 4 / RANDOM_ITEMS);
                add_request(alpha[$urandom_range(alpha_n - 1)],
                            i == 0 || $urandom_range(19) == 0,
                            i == run_len - 1 || $urandom_range(9) == 0,
                            ph, int'(ph) != ph_idx);
                ph_idx = int'(ph);
                n++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0 && !in_flight && expected_codes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("PASS adaptive_huffman_encoder");
        end else begin
            $display("FAIL adaptive_huffman_encoder");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL adaptive_huffman_encoder");
        $finish;
    end

endmodule
